### hw/rtl/bdec_pkg.sv
`timescale 1ns / 1ps

package bdec_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned DEB_W    = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_MS   = 2'd0,
        REG_COUNT_MODE    = 2'd1,
        REG_PRESSED_LEVEL = 2'd2
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOTH    = 2'd0,
        MODE_FALLING = 2'd1,
        MODE_RISING  = 2'd2
    } count_mode_t;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST      = '0;
    localparam count_mode_t       COUNT_MODE_RST    = MODE_FALLING;
    localparam logic              PRESSED_LEVEL_RST = 1'b0;

endpackage

### hw/rtl/bdec_sample_if.sv
`timescale 1ns / 1ps

interface bdec_sample_if
    import bdec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              level;
    logic [TIME_W-1:0] now_ms;
    logic              clear_count;

    modport source (output valid, output level, output now_ms, output clear_count,
                    input ready);
    modport sink   (input valid, input level, input now_ms, input clear_count,
                    output ready);
endinterface

### hw/rtl/bdec_result_if.sv
`timescale 1ns / 1ps

interface bdec_result_if
    import bdec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               steady_level;
    logic               pressed;
    logic               released;
    logic [COUNT_W-1:0] edge_count;

    modport source (output valid, output steady_level, output pressed, output released,
                    output edge_count, input ready);
    modport sink   (input valid, input steady_level, input pressed, input released,
                    input edge_count, output ready);
endinterface

### hw/rtl/bdec_cfg_if.sv
`timescale 1ns / 1ps

interface bdec_cfg_if
    import bdec_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/button_debounce_edge_counter.sv
`timescale 1ns / 1ps
// Channel  | Dir | Payload
// ---------+-----+-----------------------------------------------
// sample   | in  | level, now_ms[31:0], clear_count
// result   | out | steady_level, pressed, released, edge_count[31:0]
// cfg      | in  | index[1:0], data[15:0] (always ready)
//
// One item per cycle while results are taken; the result is valid in the cycle after acceptance.
// The debounce state updates on acceptance; the only stage is the result register.
// sample.ready drops only while a held result is not taken.
// Reset restores the register defaults and the unpressed steady level.

module button_debounce_edge_counter
    import bdec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bdec_sample_if.sink  sample,
    bdec_result_if.source result,
    bdec_cfg_if.sink     cfg
);

    logic [DEB_W-1:0]   debounce_ms_reg;
    count_mode_t        count_mode_reg;
    logic               pressed_level_reg;

    logic               raw_last_reg,    raw_last_next;
    logic [TIME_W-1:0]  change_time_reg, change_time_next;
    logic               steady_prev_reg, steady_prev_next;
    logic               steady_now_reg,  steady_now_next;
    logic [COUNT_W-1:0] edge_total_reg,  edge_total_next;

    logic               out_valid_reg;
    logic               pressed_reg,  pressed_next;
    logic               released_reg, released_next;

    logic               accept;
    logic [TIME_W-1:0]  elapsed;
    logic               update;
    logic               counted;
    logic [COUNT_W-1:0] base;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_RST;
            count_mode_reg    <= COUNT_MODE_RST;
            pressed_level_reg <= PRESSED_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg.data;
                REG_COUNT_MODE:    count_mode_reg    <= count_mode_t'(cfg.data[MODE_W-1:0]);
                REG_PRESSED_LEVEL: pressed_level_reg <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (sample.level != raw_last_reg)
            change_time_next = sample.now_ms;
        else
            change_time_next = change_time_reg;
        raw_last_next = sample.level;

        elapsed = sample.now_ms - change_time_next;
        update  = elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms_reg};

        steady_prev_next = update ? steady_now_reg : steady_prev_reg;
        steady_now_next  = update ? sample.level   : steady_now_reg;

        // steady_prev == 1 && steady_now == 0 is a falling edge
        unique case (count_mode_reg)
            MODE_BOTH:    counted = steady_prev_next != steady_now_next;
            MODE_FALLING: counted = steady_prev_next && !steady_now_next;
            MODE_RISING:  counted = !steady_prev_next && steady_now_next;
            default:      counted = 1'b0;
        endcase

        base            = sample.clear_count ? '0 : edge_total_reg;
        edge_total_next = base + {{(COUNT_W-1){1'b0}}, counted};

        pressed_next  = (steady_prev_next != steady_now_next)
                        && (steady_now_next == pressed_level_reg);
        released_next = (steady_prev_next != steady_now_next)
                        && (steady_prev_next == pressed_level_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg    <= !PRESSED_LEVEL_RST;
            change_time_reg <= '0;
            steady_prev_reg <= !PRESSED_LEVEL_RST;
            steady_now_reg  <= !PRESSED_LEVEL_RST;
            edge_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                raw_last_reg    <= raw_last_next;
                change_time_reg <= change_time_next;
                steady_prev_reg <= steady_prev_next;
                steady_now_reg  <= steady_now_next;
                edge_total_reg  <= edge_total_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.steady_level = steady_now_reg;
    assign result.pressed      = pressed_reg;
    assign result.released     = released_reg;
    assign result.edge_count   = edge_total_reg;

endmodule
